@@ rtl/spieb_pkg.sv @@
// Package for the SPI EEPROM byte access master.
// Holds the beat payload types, phase codes and command constants.
// No dependencies; every other file imports it.
`default_nettype none

package spieb_pkg;

  localparam int unsigned WaitW = 20;

  localparam logic [WaitW-1:0] WaitTicksReset = WaitW'(10000);

  // Request codes carried with each tick.
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WREN = 3'd1;
  localparam logic [2:0] PH_GAP  = 3'd2;
  localparam logic [2:0] PH_XFER = 3'd3;
  localparam logic [2:0] PH_WAIT = 3'd4;

  // EEPROM instruction bytes.
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        serial_in;
  } req_t;

  typedef struct packed {
    logic       chip_select_n;
    logic       serial_clock;
    logic       serial_out;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/spieb_in_if.sv @@
// Input channel of the SPI EEPROM master: one tick beat per handshake.
// Depends on spieb_pkg for the payload type.
`default_nettype none

interface spieb_in_if import spieb_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/spieb_out_if.sv @@
// Result channel of the SPI EEPROM master: pin levels and status per tick.
// Depends on spieb_pkg for the payload type.
`default_nettype none

interface spieb_out_if import spieb_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/spieb_step.sv @@
// Transaction sequencer: holds the SPI state and works out one tick per beat.
// Depends on spieb_pkg for types, phases and command bytes.
`default_nettype none

module spieb_step import spieb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire req_t             req_i,
  input  wire logic [WaitW-1:0] wait_ticks_i,
  output res_t                  res_o
);

  logic [2:0]       phase_q, phase_d;
  logic             rd_q, rd_d;
  logic [1:0]       byte_q, byte_d;
  logic [2:0]       bit_q, bit_d;
  logic             half_q, half_d;
  logic [7:0]       shift_q, shift_d;
  logic [15:0]      addr_q, addr_d;
  logic [7:0]       data_q, data_d;
  logic [7:0]       last_q, last_d;
  logic [WaitW-1:0] wait_q, wait_d;

  logic       req_valid;
  logic [2:0] ph_run;

  assign req_valid = (req_i.req_type == REQ_WRITE) || (req_i.req_type == REQ_READ);

  always_comb begin
    phase_d = phase_q;
    rd_d    = rd_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    half_d  = half_q;
    shift_d = shift_q;
    addr_d  = addr_q;
    data_d  = data_q;
    last_d  = last_q;
    wait_d  = wait_q;

    res_o.chip_select_n = 1'b1;
    res_o.serial_clock  = 1'b0;
    res_o.serial_out    = 1'b0;
    res_o.read_valid    = 1'b0;
    res_o.rejected      = 1'b0;

    // A request taken while idle already drives the first clock-high tick.
    if (phase_q != PH_IDLE) begin
      res_o.rejected = req_valid;
    end else if (req_valid) begin
      addr_d  = req_i.address;
      data_d  = req_i.write_data;
      rd_d    = (req_i.req_type == REQ_READ);
      phase_d = (req_i.req_type == REQ_READ) ? PH_XFER : PH_WREN;
      shift_d = (req_i.req_type == REQ_READ) ? CMD_READ : CMD_WREN;
      byte_d  = 2'd0;
      bit_d   = 3'd0;
      half_d  = 1'b0;
    end
    ph_run = phase_d;

    unique case (ph_run)
      PH_WREN, PH_XFER: begin
        res_o.chip_select_n = 1'b0;
        res_o.serial_out    = shift_d[7];
        if (!half_d) begin
          res_o.serial_clock = 1'b1;
          half_d             = 1'b1;
        end else begin
          half_d  = 1'b0;
          shift_d = {shift_d[6:0], req_i.serial_in};
          if (bit_d != 3'd7) begin
            bit_d = bit_d + 3'd1;
          end else begin
            bit_d = 3'd0;
            if (ph_run == PH_WREN) begin
              phase_d = PH_GAP;
            end else begin
              byte_d = byte_d + 2'd1;
              unique case (byte_d)
                2'd1: shift_d = addr_d[15:8];
                2'd2: shift_d = addr_d[7:0];
                2'd3: begin
                  // A read sends back the byte captured during the low address.
                  if (!rd_d) begin
                    shift_d = data_d;
                  end
                end
                default: begin
                  if (rd_d) begin
                    last_d           = shift_d;
                    res_o.read_valid = 1'b1;
                    phase_d          = PH_IDLE;
                  end else begin
                    wait_d  = wait_ticks_i;
                    phase_d = (wait_ticks_i == '0) ? PH_IDLE : PH_WAIT;
                  end
                end
              endcase
            end
          end
        end
      end
      PH_GAP: begin
        phase_d = PH_XFER;
        shift_d = CMD_WRITE;
        byte_d  = 2'd0;
        bit_d   = 3'd0;
        half_d  = 1'b0;
      end
      PH_WAIT: begin
        if (wait_d != '0) begin
          wait_d = wait_d - WaitW'(1);
        end
        if (wait_d == '0) begin
          phase_d = PH_IDLE;
        end
      end
      PH_IDLE: begin
      end
      default: phase_d = PH_IDLE;
    endcase

    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.read_data = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rd_q    <= 1'b0;
      byte_q  <= 2'd0;
      bit_q   <= 3'd0;
      half_q  <= 1'b0;
      shift_q <= 8'd0;
      addr_q  <= 16'd0;
      data_q  <= 8'd0;
      last_q  <= 8'd0;
      wait_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rd_q    <= rd_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      half_q  <= half_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
      last_q  <= last_d;
      wait_q  <= wait_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/spieb_out_stage.sv @@
// Result register of the SPI EEPROM master, holding one result beat.
// Depends on spieb_pkg for the result type.
`default_nettype none

module spieb_out_stage import spieb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  input  wire logic ready_i,
  output logic      free_o,
  output logic      valid_o,
  output res_t      res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // The register can take a new beat whenever it is empty or being drained.
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ rtl/spi_eeprom_byte_access_master_unit.sv @@
// Top level of the SPI mode-0 EEPROM byte access master.
// Depends on spieb_pkg, spieb_in_if, spieb_out_if, spieb_step and spieb_out_stage.
//
//   Channel  Direction  Carries
//   in_if    sink       one half-bit tick: request, address, data, sampled pin
//   out_if   source     pin levels, busy, read byte, read strobe, reject flag
//   cfg      write only write_wait_ticks, 20 bits
//
// One tick beat is taken per clock cycle unless stalled; its result appears on
// out_if in the next cycle, set by the single sequencer step before the result
// register. Input is stalled only while a result waits and out_if is not ready.
// Reset is asynchronous and active low: idle, chip select high, wait 10000.
`default_nettype none

module spi_eeprom_byte_access_master_unit import spieb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [WaitW-1:0] cfg_wdata_i,
  spieb_in_if.sink              in_if,
  spieb_out_if.source           out_if
);

  logic [WaitW-1:0] wait_ticks_q;
  logic             stage_free;
  logic             accept;
  res_t             step_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ticks_q <= WaitTicksReset;
    end else if (cfg_we_i) begin
      wait_ticks_q <= cfg_wdata_i;
    end
  end

  assign in_if.ready = stage_free;
  assign accept      = in_if.valid && stage_free;

  spieb_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (in_if.payload),
    .wait_ticks_i (wait_ticks_q),
    .res_o        (step_res)
  );

  spieb_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (step_res),
    .ready_i (out_if.ready),
    .free_o  (stage_free),
    .valid_o (out_if.valid),
    .res_o   (out_if.payload)
  );

`ifndef SYNTHESIS
  // A read finishes on a clock-low tick with the chip still selected.
  a_read_ends_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.payload.read_valid |->
      !out_if.payload.chip_select_n && !out_if.payload.serial_clock)
    else $error("read completed outside a selected clock-low tick");

  // Completing a read always returns the sequencer to idle.
  a_read_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.payload.read_valid |-> !out_if.payload.busy_res)
    else $error("still busy after a read completed");

  // With no result held, a tick beat must be taken at once.
  a_no_needless_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire
